### rtl/core/ssc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_pkg: shared types and constants of the selective scan channel
// Word layouts, exp lookup tables, sequencer states and saturation helper.
// ----------------------------------------------------------------------------
package ssc_pkg;

    // number of state elements held in the channel memory
    localparam int STATE_SIZE = 128;
    localparam int ADDR_W     = (STATE_SIZE > 1) ? $clog2(STATE_SIZE) : 1;

    // stream word widths
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 64;

    // decay rate after reset, 1.0 in unsigned Q4.12
    localparam logic [15:0] DECAY_RATE_RST = 16'd4096;

    // exp(-n) in Q1.16 for integer part n
    localparam logic [16:0] EXPI [16] = '{
        17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442, 17'd162, 17'd60,
        17'd22,    17'd8,     17'd3,    17'd1,    17'd0,    17'd0,   17'd0,   17'd0
    };

    // exp(-k/16) in Q1.16, one extra entry for interpolation
    localparam logic [16:0] EXPF [17] = '{
        17'd65536, 17'd61565, 17'd57835, 17'd54331, 17'd51039, 17'd47947,
        17'd45042, 17'd42313, 17'd39750, 17'd37341, 17'd35079, 17'd32954,
        17'd30957, 17'd29081, 17'd27319, 17'd25664, 17'd24109
    };

    // item sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DECAY,
        ST_TERMS,
        ST_UPDATE,
        ST_PRODUCT,
        ST_ACCUM
    } t_state;

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage
`default_nettype wire

### rtl/core/ssm_selective_scan_channel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_selective_scan_channel: one channel of a selective state-space scan
// Per word: decay = exp(-dt*rate), h' = decay*h + x*dt*B stored back in the
// state memory, and a running sum of h'*C returned on the last element.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------
//  s       | in        | i_s_tvalid / o_s_tready  | tdata, tuser first, tlast last
//  m       | out       | o_m_tvalid / i_m_tready  | tdata, tuser output_valid
//  cfg     | in        | i_cfg_valid / o_cfg_ready| decay_rate, Q4.12
//
//  A word passes the steps LOOKUP, DECAY, TERMS, UPDATE, PRODUCT and ACCUM and
//  loads the output register on leaving ACCUM; the next word is taken only in
//  IDLE. The steps follow the chain of dependent multiplies, at most two per step.
//  Reset clears control and the running sum and sets the rate to 1.0; the state
//  memory is not cleared and holds nothing valid until each element is first
//  written. A new word is taken while a result waits; ACCUM holds while full.
//
module ssm_selective_scan_channel (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // step_size[15:0], x_value[31:16], b_value[47:32], c_value[63:48],
    // element_index[70:64], init_value[102:71], zero pad[103]
    input  wire [ssc_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // first_step[0]
    input  wire                          i_s_tuser,
    input  wire                          i_s_tlast,
    input  wire                          i_s_tvalid,
    output logic                         o_s_tready,
    // new_state[31:0], output_value[63:32]
    output logic [ssc_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // output_valid[0]
    output logic                         o_m_tuser,
    output logic                         o_m_tvalid,
    input  wire                          i_m_tready,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [15:0]                   i_cfg_data
);
    import ssc_pkg::*;

    // control
    t_state                r_state;
    t_state                n_state;
    logic [15:0]           r_decay_rate;
    logic signed [31:0]    r_step_sum;
    logic signed [31:0]    n_step_sum;
    logic                  r_out_valid;
    logic                  s_accept;
    logic                  out_free;
    logic                  load_out;
    logic                  mem_wr;

    // state memory
    logic [31:0]           mem_state [STATE_SIZE];
    logic [31:0]           r_rd_data;
    logic [ADDR_W-1:0]     rd_addr;

    // captured word
    logic [15:0]           r_dt;
    logic signed [15:0]    r_x;
    logic signed [15:0]    r_b;
    logic signed [15:0]    r_c;
    logic [ADDR_W-1:0]     r_addr;
    logic                  r_in_range;
    logic                  r_first;
    logic signed [31:0]    r_init;
    logic                  r_last;

    // datapath registers
    logic [31:0]           r_a;
    logic [16:0]           r_frac;
    logic signed [31:0]    r_xb;
    logic signed [31:0]    r_h_old;
    logic [16:0]           r_decay;
    logic signed [48:0]    r_xbd;
    logic signed [33:0]    r_dterm;
    logic signed [29:0]    r_iterm;
    logic signed [31:0]    r_h_new;
    logic signed [34:0]    r_pterm;
    logic [31:0]           r_out_state;
    logic [31:0]           r_out_value;
    logic                  r_out_flag;

    // datapath combinational
    logic [16:0]           ef0;
    logic [16:0]           ef1;
    logic [16:0]           ef_diff;
    logic [24:0]           interp;
    logic [16:0]           frac_c;
    logic [33:0]           decay_prod;
    logic [34:0]           decay_rnd;
    logic signed [16:0]    dt_s;
    logic signed [17:0]    decay_s;
    logic signed [49:0]    hd_rnd;
    logic signed [48:0]    iterm_rnd;
    logic signed [34:0]    upd_sum;
    logic signed [47:0]    pc_rnd;
    logic signed [35:0]    acc_sum;
    logic signed [31:0]    acc_sat;

    // handshake decode
    always_comb begin
        o_s_tready  = (r_state == ST_IDLE);
        o_cfg_ready = 1'b1;
        s_accept    = i_s_tvalid && o_s_tready;
        out_free    = !r_out_valid || i_m_tready;
        load_out    = (r_state == ST_ACCUM) && out_free;
        mem_wr      = (r_state == ST_PRODUCT) && r_in_range;
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (s_accept) n_state = ST_LOOKUP;
            ST_LOOKUP:  n_state = ST_DECAY;
            ST_DECAY:   n_state = ST_TERMS;
            ST_TERMS:   n_state = ST_UPDATE;
            ST_UPDATE:  n_state = ST_PRODUCT;
            ST_PRODUCT: n_state = ST_ACCUM;
            ST_ACCUM:   if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_decay_rate <= DECAY_RATE_RST;
            r_step_sum   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_decay_rate <= i_cfg_data;
            end
            if (load_out) begin
                r_step_sum  <= n_step_sum;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // memory read at acceptance, write back of the updated element
    assign rd_addr = ADDR_W'(i_s_tdata[70:64]);

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem_state[rd_addr];
        if (mem_wr) begin
            mem_state[r_addr] <= r_h_new;
        end
    end

    // decay interpolation between table points
    always_comb begin
        ef0     = EXPF[{1'b0, r_a[27:24]}];
        ef1     = EXPF[{1'b0, r_a[27:24]} + 5'd1];
        ef_diff = ef0 - ef1;
        interp  = {8'd0, ef_diff} * {17'd0, r_a[23:16]} + 25'd128;
        frac_c  = ef0 - interp[24:8];
    end

    // exp scaling, the two update terms and the output product
    always_comb begin
        decay_prod = {17'd0, EXPI[r_a[31:28]]} * {17'd0, r_frac};
        decay_rnd  = {1'b0, decay_prod} + 35'd32768;
        dt_s       = {1'b0, r_dt};
        decay_s    = {1'b0, r_decay};
        hd_rnd     = 50'(r_h_old) * 50'(decay_s) + 50'sd32768;
        iterm_rnd  = r_xbd + 49'sd262144;
        upd_sum    = 35'(r_dterm) + 35'(r_iterm);
        pc_rnd     = 48'(r_h_new) * 48'(r_c) + 48'sd4096;
    end

    // running sum of h' * C
    always_comb begin
        acc_sum    = 36'(r_step_sum) + 36'(r_pterm);
        acc_sat    = sat32(40'(acc_sum));
        n_step_sum = r_last ? 32'sd0 : acc_sat;
    end

    // datapath registers, one stage per sequencer step
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_dt       <= i_s_tdata[15:0];
            r_x        <= i_s_tdata[31:16];
            r_b        <= i_s_tdata[47:32];
            r_c        <= i_s_tdata[63:48];
            r_addr     <= rd_addr;
            r_in_range <= ({25'd0, i_s_tdata[70:64]} < 32'(STATE_SIZE));
            r_init     <= i_s_tdata[102:71];
            r_first    <= i_s_tuser;
            r_last     <= i_s_tlast;
            r_a        <= {16'd0, i_s_tdata[15:0]} * {16'd0, r_decay_rate};
        end
        if (r_state == ST_LOOKUP) begin
            r_h_old <= r_first ? r_init : (r_in_range ? r_rd_data : 32'sd0);
            r_frac  <= frac_c;
            r_xb    <= 32'(r_x) * 32'(r_b);
        end
        if (r_state == ST_DECAY) begin
            r_decay <= decay_rnd[32:16];
            r_xbd   <= 49'(r_xb) * 49'(dt_s);
        end
        if (r_state == ST_TERMS) begin
            r_dterm <= hd_rnd[49:16];
            r_iterm <= iterm_rnd[48:19];
        end
        if (r_state == ST_UPDATE) begin
            r_h_new <= sat32(40'(upd_sum));
        end
        if (r_state == ST_PRODUCT) begin
            r_pterm <= pc_rnd[47:13];
        end
        if (load_out) begin
            r_out_state <= r_h_new;
            r_out_value <= r_last ? acc_sat : 32'd0;
            r_out_flag  <= r_last;
        end
    end

    // output word
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_value, r_out_state};
    assign o_m_tuser  = r_out_flag;

endmodule
`default_nettype wire

### rtl/core/ssc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_checker: port-level checks of the selective scan channel
// Watches the stream handshakes and the result word over time.
// ----------------------------------------------------------------------------
module ssc_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_s_tvalid,
    input wire                               o_s_tready,
    input wire                               o_m_tvalid,
    input wire                               i_m_tready,
    input wire [ssc_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    input wire                               o_m_tuser
);
    import ssc_pkg::*;

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result word dropped while stalled");

    // one word at a time: no acceptance right after an acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second word taken while one is in work");

    // a fresh word cannot produce a result in the very next cycle
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !o_m_tvalid |=> !o_m_tvalid)
        else $error("result appeared too early");

    // the sum field is zero unless it carries a completed step
    a_sum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[63:32] == 32'd0)
        else $error("sum field nonzero on a non-final element");

    // nothing offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result offered after reset");

endmodule

bind ssm_selective_scan_channel ssc_checker u_ssc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire

### tb/tb_ssm_selective_scan_channel.sv
// ----------------------------------------------------------------------------
// tb_ssm_selective_scan_channel: self-checking bench of the selective scan channel
// Streams timesteps of state-element words with random content and bursty
// gaps on both sides, predicts every result word from its own fixed-point
// model of the recurrence, and changes the decay rate between phases.
// ----------------------------------------------------------------------------
module tb_ssm_selective_scan_channel;

    // one input word, in field order
    typedef struct {
        logic [15:0]        dt;
        logic signed [15:0] x;
        logic signed [15:0] b;
        logic signed [15:0] c;
        logic [6:0]         idx;
        logic               first;
        logic signed [31:0] init;
        logic               last;
    } t_scan_item;

    // one result word
    typedef struct {
        logic signed [31:0] state;
        logic signed [31:0] sum;
        logic               flag;
    } t_scan_result;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic [ssc_pkg::IN_TDATA_W-1:0]    i_s_tdata   = '0;
    logic                              i_s_tuser   = 1'b0;
    logic                              i_s_tlast   = 1'b0;
    logic                              i_s_tvalid  = 1'b0;
    logic                              o_s_tready;
    logic [ssc_pkg::OUT_TDATA_W-1:0]   o_m_tdata;
    logic                              o_m_tuser;
    logic                              o_m_tvalid;
    logic                              i_m_tready  = 1'b0;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [15:0]                       i_cfg_data  = '0;

    // exp(-n) and exp(-k/16) in Q1.16
    longint exp_int_tab [16] = '{
        65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1, 0, 0, 0, 0
    };
    longint exp_frac_tab [17] = '{
        65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313, 39750,
        37341, 35079, 32954, 30957, 29081, 27319, 25664, 24109
    };

    // predicted block state
    logic signed [31:0] state_mem [ssc_pkg::STATE_SIZE];
    logic signed [31:0] step_acc  = '0;
    logic [15:0]        rate_q412 = ssc_pkg::DECAY_RATE_RST;

    // elements that a queued word has already written
    bit                 elem_seeded [ssc_pkg::STATE_SIZE];

    t_scan_item         word_q [$];
    t_scan_result       pending_results [$];
    t_scan_item         drive_item;

    int                 items_total    = 0;
    int                 items_accepted = 0;
    int                 mismatch_count = 0;
    int                 gap_odds       = 0;
    int                 s_gap          = 0;
    int                 m_gap          = 0;
    bit                 s_fire         = 1'b0;

    ssm_selective_scan_channel dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] clamp_q823(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // decay = exp(-dt * rate), unsigned Q1.16
    function automatic longint exp_decay(input logic [15:0] dt, input logic [15:0] rate);
        logic [31:0] prod;
        int          n;
        int          k;
        int          w;
        longint      frac;
        prod = dt * rate;
        n    = prod[31:28];
        k    = prod[27:24];
        w    = prod[23:16];
        frac = exp_frac_tab[k] - (((exp_frac_tab[k] - exp_frac_tab[k + 1]) * w + 128) >>> 8);
        return (exp_int_tab[n] * frac + 32768) >>> 16;
    endfunction

    // one recurrence step on the predicted state
    task automatic advance_scan(input t_scan_item it);
        longint             h_old;
        longint             dterm;
        longint             iterm;
        longint             pterm;
        logic signed [31:0] h_new;
        t_scan_result       res;
        h_old = it.first ? longint'(it.init) : longint'(state_mem[it.idx]);
        dterm = (h_old * exp_decay(it.dt, rate_q412) + 64'sd32768) >>> 16;
        iterm = (longint'(it.x) * longint'(it.b) * longint'(it.dt) + 64'sd262144) >>> 19;
        h_new = clamp_q823(dterm + iterm);
        state_mem[it.idx] = h_new;
        pterm    = (longint'(h_new) * longint'(it.c) + 64'sd4096) >>> 13;
        step_acc = clamp_q823(longint'(step_acc) + pterm);
        res.state = h_new;
        res.flag  = it.last;
        res.sum   = it.last ? step_acc : 32'sd0;
        if (it.last) begin
            step_acc = '0;
        end
        pending_results.insert(pending_results.size(), res);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    // queue one word; a never-written element is always loaded from init
    task automatic push_item(input logic [15:0] dt, input logic [15:0] x,
                             input logic [15:0] b, input logic [15:0] c,
                             input logic [6:0] idx, input logic first,
                             input logic [31:0] init, input logic last);
        t_scan_item it;
        it.dt    = dt;
        it.x     = x;
        it.b     = b;
        it.c     = c;
        it.idx   = idx;
        it.first = first | !elem_seeded[idx];
        it.init  = init;
        it.last  = last;
        elem_seeded[idx] = 1'b1;
        word_q.insert(word_q.size(), it);
        items_total++;
    endtask

    // coefficient with extra weight on the extremes
    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // step size: full range, small, or an extreme
    function automatic logic [15:0] pick_step();
        case ($urandom_range(0, 7))
            0:       return 16'hFFFF;
            1:       return 16'h0000;
            2, 3:    return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly well-formed timesteps over a run of elements, some loose words
    task automatic push_random(input int n_items);
        int          stop_at;
        int          n_elem;
        int          n_steps;
        int          base;
        logic [15:0] dt;
        logic [15:0] xv;
        logic        fresh;
        stop_at = items_total + n_items;
        while (items_total < stop_at) begin
            if ($urandom_range(0, 9) < 8) begin
                if ($urandom_range(0, 19) == 0) begin
                    n_elem  = $urandom_range(16, 128);
                    n_steps = 1;
                end else begin
                    n_elem  = $urandom_range(1, 8);
                    n_steps = $urandom_range(1, 6);
                end
                base  = $urandom_range(0, 127);
                fresh = ($urandom_range(0, 2) == 0);
                for (int s = 0; s < n_steps; s++) begin
                    dt = pick_step();
                    xv = pick_coef();
                    for (int e = 0; e < n_elem; e++) begin
                        push_item(dt, xv, pick_coef(), pick_coef(), 7'((base + e) % 128),
                                  fresh && (s == 0), 32'($urandom), e == n_elem - 1);
                    end
                end
            end else begin
                repeat ($urandom_range(1, 5)) begin
                    push_item(pick_step(), pick_coef(), pick_coef(), pick_coef(),
                              7'($urandom), 1'($urandom), 32'($urandom), 1'($urandom));
                end
            end
        end
    endtask

    // wait for every word and result, then let the pipeline settle
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (items_accepted != items_total || pending_results.size() != 0);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_decay_rate(input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        rate_q412 = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && !s_fire) begin
            i_s_tvalid <= 1'b1;
        end else if (s_gap > 0) begin
            s_gap--;
            i_s_tvalid <= 1'b0;
        end else if (word_q.size() != 0) begin
            if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
                s_gap = $urandom_range(1, 13) - 1;
                i_s_tvalid <= 1'b0;
            end else begin
                drive_item = word_q.pop_front();
                i_s_tdata  <= {1'b0, drive_item.init, drive_item.idx, drive_item.c,
                               drive_item.b, drive_item.x, drive_item.dt};
                i_s_tuser  <= drive_item.first;
                i_s_tlast  <= drive_item.last;
                i_s_tvalid <= 1'b1;
            end
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    // result sink with stall bursts
    always @(negedge i_clk) begin
        if (m_gap > 0) begin
            m_gap--;
            i_m_tready <= 1'b0;
        end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            m_gap = $urandom_range(1, 13) - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // monitor: check result words, then predict newly accepted words
    always @(posedge i_clk) begin
        t_scan_result want;
        s_fire = i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", o_m_tdata[31:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[31:0] !== want.state) begin
                    report_mismatch("new_state", o_m_tdata[31:0], want.state);
                end
                if (o_m_tdata[63:32] !== want.sum) begin
                    report_mismatch("output_value", o_m_tdata[63:32], want.sum);
                end
                if (o_m_tuser !== want.flag) begin
                    report_mismatch("output_valid", {31'b0, o_m_tuser}, {31'b0, want.flag});
                end
            end
        end
        if (s_fire) begin
            advance_scan(drive_item);
            items_accepted++;
        end
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // phases
    initial begin
        for (int i = 0; i < ssc_pkg::STATE_SIZE; i++) begin
            state_mem[i] = '0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset rate: field extremes and bit patterns
        gap_odds = 6;
        push_item(16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd0, 1'b1, 32'h0000_0000, 1'b0);
        push_item(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 7'd127, 1'b1, 32'h7FFF_FFFF, 1'b0);
        push_item(16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 7'd1, 1'b1, 32'h8000_0000, 1'b1);
        push_item(16'h0001, 16'h7FFF, 16'h8000, 16'h7FFF, 7'd0, 1'b0, 32'h0000_0000, 1'b0);
        push_item(16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 7'd127, 1'b0, 32'hFFFF_FFFF, 1'b1);
        push_item(16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 7'd2, 1'b1, 32'h0000_0000, 1'b1);
        push_item(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 7'h55, 1'b1, 32'h5555_5555, 1'b0);
        push_item(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 7'h2A, 1'b1, 32'hAAAA_AAAA, 1'b1);
        push_item(16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF, 7'h55, 1'b0, 32'h0000_0000, 1'b1);
        push_random(250);
        wait_drained();

        // rate zero: decay of one, state and sum saturation
        write_decay_rate(16'h0000);
        gap_odds = 3;
        push_item(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 7'd3, 1'b1, 32'h7FFF_0000, 1'b0);
        push_item(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 7'd3, 1'b0, 32'h0000_0000, 1'b1);
        push_item(16'hFFFF, 16'h8000, 16'h7FFF, 16'h7FFF, 7'd4, 1'b1, 32'h8000_0000, 1'b0);
        push_item(16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 7'd4, 1'b0, 32'h0000_0000, 1'b1);
        push_random(250);
        wait_drained();

        // largest rate: decay reaches zero at full step size
        write_decay_rate(16'hFFFF);
        gap_odds = 0;
        push_item(16'hFFFF, 16'h0000, 16'h0000, 16'h7FFF, 7'd5, 1'b1, 32'h7FFF_FFFF, 1'b1);
        push_item(16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 7'd6, 1'b1, 32'h1234_5678, 1'b1);
        push_item(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 7'd6, 1'b0, 32'h0000_0000, 1'b1);
        push_random(250);
        wait_drained();

        write_decay_rate(16'($urandom));
        gap_odds = 8;
        push_random(250);
        wait_drained();

        write_decay_rate(16'h0001);
        gap_odds = 4;
        push_random(250);
        wait_drained();

        write_decay_rate(16'($urandom));
        gap_odds = 10;
        push_random(250);
        wait_drained();

        // closing stretch without gaps or stalls
        write_decay_rate(ssc_pkg::DECAY_RATE_RST);
        gap_odds = 0;
        push_random(150);
        wait_drained();
        repeat (10) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### ssm_selective_scan_channel.f
rtl/core/ssc_pkg.sv
rtl/core/ssm_selective_scan_channel.sv
rtl/core/ssc_checker.sv
tb/tb_ssm_selective_scan_channel.sv
